// ----- sv/four_key_setpoint_panel_macros.svh -----
// Assertion macros shared by the panel RTL.
`ifndef FOUR_KEY_SETPOINT_PANEL_MACROS_SVH
`define FOUR_KEY_SETPOINT_PANEL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/fsp_pkg.sv -----
package fsp_pkg;

	localparam int TICK_BITS = 9;
	localparam int TEMP_BITS = 12;
	localparam int TIME_BITS = 16;
	localparam int IN_BYTES_BITS = 8;
	localparam int OUT_BYTES_BITS = 40;

	localparam logic [TEMP_BITS-1:0] TEMP_STEP = 12'd10;
	localparam logic [TIME_BITS-1:0] TIME_STEP_FINE = 16'd5;
	localparam logic [TIME_BITS-1:0] TIME_STEP_COARSE = 16'd60;
	localparam logic [TIME_BITS-1:0] TIME_COARSE_FROM = 16'd60;

	typedef enum logic [2:0] {
		REG_TEMP_MIN = 3'd0,
		REG_TEMP_MAX = 3'd1,
		REG_TIME_MIN = 3'd2,
		REG_TIME_MAX = 3'd3,
		REG_CLICK_MIN = 3'd4,
		REG_CLICK_MAX = 3'd5,
		REG_REPEAT_AT = 3'd6,
		REG_REPEAT_RELOAD = 3'd7
	} reg_index_t;

	typedef enum logic [1:0] {
		RUN_STOPPED = 2'd0,
		RUN_RUNNING = 2'd1,
		RUN_PAUSED = 2'd2
	} run_mode_t;

	localparam logic [1:0] EDIT_NONE = 2'd0;
	localparam logic [1:0] EDIT_TEMP = 2'd1;
	localparam logic [1:0] EDIT_TIME = 2'd2;

	typedef struct packed {
		logic [TICK_BITS-1:0] click_min;
		logic [TICK_BITS-1:0] click_max;
		logic [TICK_BITS-1:0] repeat_at;
		logic [TICK_BITS-1:0] repeat_reload;
	} tick_cfg_t;

	typedef struct packed {
		logic [TEMP_BITS-1:0] temp_floor;
		logic [TEMP_BITS-1:0] temp_ceil;
		logic [TIME_BITS-1:0] time_floor;
		logic [TIME_BITS-1:0] time_ceil;
	} limit_cfg_t;

	typedef struct packed {
		logic [TEMP_BITS-1:0] temp;
		logic [TIME_BITS-1:0] time_val;
	} setpoints_t;

endpackage

// ----- sv/fsp_key.sv -----
module fsp_key #(
	parameter int COUNT_BITS = 9,
	parameter bit REPEAT = 1'b0
) (
	input logic pressed,
	input fsp_pkg::tick_cfg_t cfg,
	input logic [COUNT_BITS-1:0] cnt_cur,
	input logic act_cur,
	input logic long_cur,
	output logic [COUNT_BITS-1:0] cnt_nxt,
	output logic act_nxt,
	output logic long_nxt,
	output logic event_hit
);

	localparam int CW = (COUNT_BITS > fsp_pkg::TICK_BITS) ? COUNT_BITS : fsp_pkg::TICK_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic count_en;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] reload_sat;
	logic [CW-1:0] cnt_w;
	logic [CW-1:0] max_w;
	logic [CW-1:0] reload_w;

	assign max_w = CW'(COUNT_MAX);
	assign reload_w = CW'(cfg.repeat_reload);
	assign reload_sat = (reload_w < max_w) ? COUNT_BITS'(reload_w) : COUNT_MAX;
	assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
	// A long-held menu or start key stops counting until released.
	assign count_en = pressed && (REPEAT || !long_cur);

	always_comb begin
		cnt_nxt = cnt_cur;
		act_nxt = act_cur;
		long_nxt = long_cur;
		event_hit = 1'b0;
		if (count_en) begin
			cnt_nxt = cnt_inc;
			act_nxt = 1'b1;
		end
		cnt_w = CW'(cnt_nxt);
		if (act_nxt) begin
			if (!pressed) begin
				event_hit = (cnt_w > CW'(cfg.click_min)) && (cnt_w < CW'(cfg.click_max));
				act_nxt = 1'b0;
				long_nxt = 1'b0;
				cnt_nxt = '0;
				cnt_w = '0;
			end
			if (REPEAT) begin
				if (cnt_w > CW'(cfg.repeat_at)) begin
					event_hit = 1'b1;
					act_nxt = 1'b0;
					cnt_nxt = reload_sat;
				end
			end else if (cnt_w > CW'(cfg.click_max)) begin
				long_nxt = 1'b1;
			end
		end
		if (REPEAT) begin
			long_nxt = 1'b0;
		end
	end

endmodule

// ----- sv/fsp_adjust.sv -----
module fsp_adjust (
	input logic step_en,
	input logic step_up,
	input logic [1:0] edit_sel,
	input fsp_pkg::limit_cfg_t lim,
	input fsp_pkg::setpoints_t cur,
	output fsp_pkg::setpoints_t nxt,
	output logic changed
);

	logic [fsp_pkg::TEMP_BITS:0] temp_hi;
	logic [fsp_pkg::TEMP_BITS:0] temp_lo_edge;
	logic [fsp_pkg::TIME_BITS-1:0] time_step;
	logic [fsp_pkg::TIME_BITS:0] time_hi;
	logic [fsp_pkg::TIME_BITS:0] time_lo_edge;

	assign temp_hi = {1'b0, cur.temp} + {1'b0, fsp_pkg::TEMP_STEP};
	assign temp_lo_edge = {1'b0, lim.temp_floor} + {1'b0, fsp_pkg::TEMP_STEP};
	assign time_step = (cur.time_val < fsp_pkg::TIME_COARSE_FROM) ?
		fsp_pkg::TIME_STEP_FINE : fsp_pkg::TIME_STEP_COARSE;
	assign time_hi = {1'b0, cur.time_val} + {1'b0, time_step};
	assign time_lo_edge = {1'b0, lim.time_floor} + {1'b0, time_step};

	// Stepping down clamps when the value would land below the minimum,
	// which is checked as value < minimum + step so nothing wraps.
	always_comb begin
		nxt = cur;
		changed = 1'b0;
		if (step_en && edit_sel == fsp_pkg::EDIT_TEMP) begin
			changed = 1'b1;
			if (step_up) begin
				nxt.temp = (temp_hi > {1'b0, lim.temp_ceil}) ?
					lim.temp_ceil : temp_hi[fsp_pkg::TEMP_BITS-1:0];
			end else begin
				nxt.temp = ({1'b0, cur.temp} < temp_lo_edge) ?
					lim.temp_floor : cur.temp - fsp_pkg::TEMP_STEP;
			end
		end else if (step_en && edit_sel == fsp_pkg::EDIT_TIME) begin
			changed = 1'b1;
			if (step_up) begin
				nxt.time_val = (time_hi > {1'b0, lim.time_ceil}) ?
					lim.time_ceil : time_hi[fsp_pkg::TIME_BITS-1:0];
			end else begin
				nxt.time_val = ({1'b0, cur.time_val} < time_lo_edge) ?
					lim.time_floor : cur.time_val - time_step;
			end
		end
	end

endmodule

// ----- sv/four_key_setpoint_panel.sv -----
// Channel  | Direction | Handshake          | Payload
// s_*      | in        | s_tvalid/s_tready  | s_tdata: one scan tick of key levels
// m_*      | out       | m_tvalid/m_tready  | m_tdata: panel state and pulses
// cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data: register write
//
// A tick is registered on entry and then evaluated into the result register,
// with one short key pass between the two registers; a new tick can be taken
// every cycle while the result is not stalled.
// Reset clears all hold counters, key flags, run state and setpoints and
// loads the register defaults. A stalled result holds the input stage, which
// then holds s_tready low. Configuration writes are always ready.
`include "four_key_setpoint_panel_macros.svh"

module four_key_setpoint_panel #(
	parameter int COUNT_BITS = 9
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// [0] menu_pressed, [1] up_pressed, [2] down_pressed, [3] start_pressed, [7:4] zero
	input logic [fsp_pkg::IN_BYTES_BITS-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// [1:0] run_state, [3:2] edit_field, [15:4] temp_setpoint,
	// [31:16] time_setpoint, [32] beep_request, [33] hold_display,
	// [34] blink_request, [35] clear_display, [36] start_preset, [39:37] zero
	output logic [fsp_pkg::OUT_BYTES_BITS-1:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);

	localparam int KM = 0;
	localparam int KU = 1;
	localparam int KD = 2;
	localparam int KS = 3;

	fsp_pkg::tick_cfg_t tick_cfg_q;
	fsp_pkg::limit_cfg_t lim_cfg_q;

	logic valid_s1;
	logic [3:0] key_s1;
	logic fire;

	logic [COUNT_BITS-1:0] cnt_q [4];
	logic [COUNT_BITS-1:0] cnt_d [4];
	logic [3:0] act_q;
	logic [3:0] act_d;
	logic [1:0] long_q;
	logic [1:0] long_d;
	logic [3:0] key_ev;

	fsp_pkg::run_mode_t run_q;
	fsp_pkg::run_mode_t run_d;
	logic [1:0] edit_q;
	logic [1:0] edit_menu;
	logic [1:0] edit_d;
	fsp_pkg::setpoints_t sp_q;
	fsp_pkg::setpoints_t sp_up;
	fsp_pkg::setpoints_t sp_dn;
	logic chg_up;
	logic chg_dn;
	logic start_go;

	logic pulse_beep;
	logic pulse_hold;
	logic pulse_blink;
	logic pulse_clear;
	logic pulse_preset;

	logic out_valid_q;
	logic [fsp_pkg::OUT_BYTES_BITS-1:0] res_q;

	assign cfg_ready = 1'b1;
	assign fire = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign m_tvalid = out_valid_q;
	assign m_tdata = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_cfg_q.temp_floor <= 12'd0;
			lim_cfg_q.temp_ceil <= 12'd4095;
			lim_cfg_q.time_floor <= 16'd0;
			lim_cfg_q.time_ceil <= 16'd65535;
			tick_cfg_q.click_min <= 9'd5;
			tick_cfg_q.click_max <= 9'd150;
			tick_cfg_q.repeat_at <= 9'd190;
			tick_cfg_q.repeat_reload <= 9'd188;
		end else if (cfg_valid && cfg_ready) begin
			unique case (fsp_pkg::reg_index_t'(cfg_index))
				fsp_pkg::REG_TEMP_MIN: lim_cfg_q.temp_floor <= cfg_data[11:0];
				fsp_pkg::REG_TEMP_MAX: lim_cfg_q.temp_ceil <= cfg_data[11:0];
				fsp_pkg::REG_TIME_MIN: lim_cfg_q.time_floor <= cfg_data;
				fsp_pkg::REG_TIME_MAX: lim_cfg_q.time_ceil <= cfg_data;
				fsp_pkg::REG_CLICK_MIN: tick_cfg_q.click_min <= cfg_data[8:0];
				fsp_pkg::REG_CLICK_MAX: tick_cfg_q.click_max <= cfg_data[8:0];
				fsp_pkg::REG_REPEAT_AT: tick_cfg_q.repeat_at <= cfg_data[8:0];
				fsp_pkg::REG_REPEAT_RELOAD: tick_cfg_q.repeat_reload <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_s1 <= s_tdata[3:0];
		end
	end

	fsp_key #(.COUNT_BITS(COUNT_BITS), .REPEAT(1'b0)) u_key_menu (
		.pressed(key_s1[KM]), .cfg(tick_cfg_q),
		.cnt_cur(cnt_q[KM]), .act_cur(act_q[KM]), .long_cur(long_q[0]),
		.cnt_nxt(cnt_d[KM]), .act_nxt(act_d[KM]), .long_nxt(long_d[0]),
		.event_hit(key_ev[KM])
	);

	fsp_key #(.COUNT_BITS(COUNT_BITS), .REPEAT(1'b1)) u_key_up (
		.pressed(key_s1[KU]), .cfg(tick_cfg_q),
		.cnt_cur(cnt_q[KU]), .act_cur(act_q[KU]), .long_cur(1'b0),
		.cnt_nxt(cnt_d[KU]), .act_nxt(act_d[KU]), .long_nxt(),
		.event_hit(key_ev[KU])
	);

	fsp_key #(.COUNT_BITS(COUNT_BITS), .REPEAT(1'b1)) u_key_down (
		.pressed(key_s1[KD]), .cfg(tick_cfg_q),
		.cnt_cur(cnt_q[KD]), .act_cur(act_q[KD]), .long_cur(1'b0),
		.cnt_nxt(cnt_d[KD]), .act_nxt(act_d[KD]), .long_nxt(),
		.event_hit(key_ev[KD])
	);

	fsp_key #(.COUNT_BITS(COUNT_BITS), .REPEAT(1'b0)) u_key_start (
		.pressed(key_s1[KS]), .cfg(tick_cfg_q),
		.cnt_cur(cnt_q[KS]), .act_cur(act_q[KS]), .long_cur(long_q[1]),
		.cnt_nxt(cnt_d[KS]), .act_nxt(act_d[KS]), .long_nxt(long_d[1]),
		.event_hit(key_ev[KS])
	);

	assign edit_menu = !key_ev[KM] ? edit_q :
		(edit_q >= fsp_pkg::EDIT_TIME) ? fsp_pkg::EDIT_NONE : edit_q + 2'd1;

	// Up is applied before down, so down sees the value that up produced.
	fsp_adjust u_adj_up (
		.step_en(key_ev[KU]), .step_up(1'b1), .edit_sel(edit_menu),
		.lim(lim_cfg_q), .cur(sp_q), .nxt(sp_up), .changed(chg_up)
	);

	fsp_adjust u_adj_down (
		.step_en(key_ev[KD]), .step_up(1'b0), .edit_sel(edit_menu),
		.lim(lim_cfg_q), .cur(sp_up), .nxt(sp_dn), .changed(chg_dn)
	);

	assign start_go = key_ev[KS] && (run_q != fsp_pkg::RUN_RUNNING);

	always_comb begin
		run_d = run_q;
		edit_d = edit_menu;
		if (key_ev[KS]) begin
			if (run_q == fsp_pkg::RUN_RUNNING) begin
				run_d = fsp_pkg::RUN_PAUSED;
			end else begin
				run_d = fsp_pkg::RUN_RUNNING;
				edit_d = fsp_pkg::EDIT_NONE;
			end
		end
	end

	assign pulse_beep = key_ev[KM] || key_ev[KS];
	assign pulse_hold = (key_ev[KM] || chg_up || chg_dn) && !start_go;
	assign pulse_blink = pulse_hold;
	assign pulse_clear = start_go;
	assign pulse_preset = start_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= '0;
			end
			act_q <= '0;
			long_q <= '0;
			run_q <= fsp_pkg::RUN_STOPPED;
			edit_q <= fsp_pkg::EDIT_NONE;
			sp_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				for (int i = 0; i < 4; i++) begin
					cnt_q[i] <= cnt_d[i];
				end
				act_q <= act_d;
				long_q <= long_d;
				run_q <= run_d;
				edit_q <= edit_d;
				sp_q <= sp_dn;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= {3'b000, pulse_preset, pulse_clear, pulse_blink, pulse_hold,
				pulse_beep, sp_dn.time_val, sp_dn.temp, edit_d, run_d};
		end
	end

	`FSP_ASSERT_NOW(a_no_accept_when_full, s_tvalid && s_tready, !valid_s1 || fire, "tick accepted while input stage is blocked")
	`FSP_ASSERT_NOW(a_start_clears_edit, fire && start_go, edit_d == fsp_pkg::EDIT_NONE && !pulse_hold && run_d == fsp_pkg::RUN_RUNNING, "start from idle did not clear edit state")
	`FSP_ASSERT_NEXT(a_long_hold_freezes, fire && long_q[0] && key_s1[KM], cnt_q[KM] == $past(cnt_q[KM]), "long-held menu counter moved")
	`FSP_ASSERT_NOW(a_edit_range, fire, edit_d != 2'd3, "edit field left its range")

endmodule
